// ===== hdl/rtc_time_sync_check_unit_defines.svh =====
// Assertion macros shared by the checker of the time synchronisation check.
// Depends on nothing; the using module must provide clk_i and rst_ni.
`ifndef RTC_TIME_SYNC_CHECK_UNIT_DEFINES_SVH
`define RTC_TIME_SYNC_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTCSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTCSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rtcsc_pkg.sv =====
// Types, constants and BCD helper functions of the time synchronisation check.
// Used by every module of the block; depends on nothing.
package rtcsc_pkg;

  localparam int unsigned NUM_STAGES = 6;

  localparam logic [7:0] CFG_MIN_YEAR    = 8'd0;
  localparam logic [7:0] CFG_MIN_MONTH   = 8'd1;
  localparam logic [7:0] CFG_MIN_DAY     = 8'd2;
  localparam logic [7:0] CFG_DRIFT_LIMIT = 8'd3;

  localparam logic [6:0]  RST_MIN_YEAR    = 7'd24;
  localparam logic [3:0]  RST_MIN_MONTH   = 4'd1;
  localparam logic [4:0]  RST_MIN_DAY     = 5'd1;
  localparam logic [15:0] RST_DRIFT_LIMIT = 16'd2;

  localparam logic [7:0] MASTER_BYTES = 8'd7;

  localparam logic [7:0] MAX_SEC   = 8'd59;
  localparam logic [7:0] MAX_MIN   = 8'd59;
  localparam logic [7:0] MAX_HOUR  = 8'd23;
  localparam logic [7:0] MAX_WDAY  = 8'd7;
  localparam logic [7:0] MAX_DAY   = 8'd31;
  localparam logic [7:0] MAX_MONTH = 8'd12;
  localparam logic [7:0] MAX_YEAR  = 8'd99;

  localparam logic [3:0] MAX_DIGIT = 4'h9;

  localparam int unsigned BASE_YEAR      = 2000;
  localparam int unsigned DAYS_PER_YEAR  = 372;
  localparam int unsigned DAYS_PER_MONTH = 31;
  localparam int unsigned HOURS_PER_DAY  = 24;
  localparam int unsigned MINS_PER_HOUR  = 60;
  localparam int unsigned SECS_PER_MIN   = 60;

  typedef enum logic [1:0] {
    VERDICT_REJECT = 2'd0,
    VERDICT_RTC_BAD = 2'd1,
    VERDICT_DRIFT  = 2'd2,
    VERDICT_OK     = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [6:0]  min_year;
    logic [3:0]  min_month;
    logic [4:0]  min_day;
    logic [15:0] drift_limit;
  } cfg_t;

  // Decoded fields of one time, narrowed to the range of a valid value.
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tval_t;

  // Advance enables of the second-count stages two to five.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  function automatic logic bcd_ok(input logic [7:0] b, input logic [7:0] max_dec);
    return (b[7:4] <= MAX_DIGIT) && (b[3:0] <= MAX_DIGIT) && (bcd_val(b) <= max_dec);
  endfunction

endpackage

// ===== hdl/rtcsc_time_dec.sv =====
// Decodes one seven-byte BCD time and checks it against the digit, range
// and minimum-date rules. Depends on rtcsc_pkg.
module rtcsc_time_dec (
  input  logic [55:0]       time_i,
  input  rtcsc_pkg::cfg_t   cfg_i,
  output rtcsc_pkg::tval_t  val_o,
  output logic              ok_o
);

  logic [7:0] b_sec, b_min, b_hour, b_wday, b_day, b_mon, b_year;
  logic [7:0] v_sec, v_min, v_hour, v_wday, v_day, v_mon, v_year;
  logic       digits_ok, fields_ok, before_min;

  assign b_sec  = time_i[7:0];
  assign b_min  = time_i[15:8];
  assign b_hour = time_i[23:16];
  assign b_wday = time_i[31:24];
  assign b_day  = time_i[39:32];
  assign b_mon  = time_i[47:40];
  assign b_year = time_i[55:48];

  assign v_sec  = rtcsc_pkg::bcd_val(b_sec);
  assign v_min  = rtcsc_pkg::bcd_val(b_min);
  assign v_hour = rtcsc_pkg::bcd_val(b_hour);
  assign v_wday = rtcsc_pkg::bcd_val(b_wday);
  assign v_day  = rtcsc_pkg::bcd_val(b_day);
  assign v_mon  = rtcsc_pkg::bcd_val(b_mon);
  assign v_year = rtcsc_pkg::bcd_val(b_year);

  assign digits_ok = rtcsc_pkg::bcd_ok(b_sec,  rtcsc_pkg::MAX_SEC)
                  && rtcsc_pkg::bcd_ok(b_min,  rtcsc_pkg::MAX_MIN)
                  && rtcsc_pkg::bcd_ok(b_hour, rtcsc_pkg::MAX_HOUR)
                  && rtcsc_pkg::bcd_ok(b_wday, rtcsc_pkg::MAX_WDAY)
                  && rtcsc_pkg::bcd_ok(b_day,  rtcsc_pkg::MAX_DAY)
                  && rtcsc_pkg::bcd_ok(b_mon,  rtcsc_pkg::MAX_MONTH)
                  && rtcsc_pkg::bcd_ok(b_year, rtcsc_pkg::MAX_YEAR);

  assign fields_ok = (v_wday != 8'd0) && (v_day != 8'd0) && (v_mon != 8'd0);

  // The minimum registers are compared as written, even when out of range.
  always_comb begin
    before_min = 1'b0;
    if (v_year < 8'(cfg_i.min_year)) begin
      before_min = 1'b1;
    end else if (v_year == 8'(cfg_i.min_year)) begin
      if (v_mon < 8'(cfg_i.min_month)) begin
        before_min = 1'b1;
      end else if (v_mon == 8'(cfg_i.min_month) && v_day < 8'(cfg_i.min_day)) begin
        before_min = 1'b1;
      end
    end
  end

  assign ok_o = digits_ok && fields_ok && !before_min;

  assign val_o.year   = 7'(v_year);
  assign val_o.month  = 4'(v_mon);
  assign val_o.day    = 5'(v_day);
  assign val_o.hour   = 5'(v_hour);
  assign val_o.minute = 6'(v_min);
  assign val_o.second = 6'(v_sec);

endmodule

// ===== hdl/rtcsc_sec_pipe.sv =====
// Four-stage constant-multiplier chain that turns decoded time fields into
// an approximate 32-bit second count. Depends on rtcsc_pkg.
module rtcsc_sec_pipe (
  input  logic              clk_i,
  input  rtcsc_pkg::adv_t   adv_i,
  input  rtcsc_pkg::tval_t  val_i,
  output logic [31:0]       secs_o
);

  logic [11:0] yr_full;
  logic [19:0] days_d, days_q;
  logic [24:0] hrs_d, hrs_q;
  logic [30:0] mins_d, mins_q;
  logic [31:0] secs_d, secs_q;
  logic [4:0]  hour_s2_q;
  logic [5:0]  min_s2_q, min_s3_q;
  logic [5:0]  sec_s2_q, sec_s3_q, sec_s4_q;

  assign yr_full = 12'(rtcsc_pkg::BASE_YEAR) + 12'(val_i.year);
  assign days_d  = 20'(32'(yr_full) * 32'(rtcsc_pkg::DAYS_PER_YEAR)
                     + 32'(val_i.month) * 32'(rtcsc_pkg::DAYS_PER_MONTH)
                     + 32'(val_i.day));
  assign hrs_d   = 25'(32'(days_q) * 32'(rtcsc_pkg::HOURS_PER_DAY) + 32'(hour_s2_q));
  assign mins_d  = 31'(32'(hrs_q) * 32'(rtcsc_pkg::MINS_PER_HOUR) + 32'(min_s3_q));
  // The count wraps modulo 2^32 here, as the 32-bit arithmetic does.
  assign secs_d  = 32'(mins_q) * 32'(rtcsc_pkg::SECS_PER_MIN) + 32'(sec_s4_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      days_q    <= days_d;
      hour_s2_q <= val_i.hour;
      min_s2_q  <= val_i.minute;
      sec_s2_q  <= val_i.second;
    end
    if (adv_i.s3) begin
      hrs_q    <= hrs_d;
      min_s3_q <= min_s2_q;
      sec_s3_q <= sec_s2_q;
    end
    if (adv_i.s4) begin
      mins_q   <= mins_d;
      sec_s4_q <= sec_s3_q;
    end
    if (adv_i.s5) begin
      secs_q <= secs_d;
    end
  end

  assign secs_o = secs_q;

endmodule

// ===== hdl/rtc_time_sync_check_unit.sv =====
// Top level of the time synchronisation check: decode, second-count pipeline,
// compare and output stage. Depends on rtcsc_pkg, rtcsc_time_dec, rtcsc_sec_pipe.

// The block takes one master/RTC time pair per cycle while input ready is high
// and returns one verdict per pair. Each pair passes six register stages: BCD
// decode and checks, day count, hour count, minute count, second count, and the
// drift compare that feeds the output register. Each stage moves on when its
// successor has room, so a stall on the output fills the pipeline before input
// ready falls. Configuration writes are always accepted and must only be made
// while the block is empty; a write to an index beyond the four registers is
// ignored.
module rtc_time_sync_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [55:0] master_time_i,
  input  logic [7:0]  master_count_i,
  input  logic [55:0] rtc_time_i,
  input  logic        rtc_read_ok_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic        write_rtc_o,
  output logic [31:0] drift_seconds_o
);

  localparam int unsigned LAST = rtcsc_pkg::NUM_STAGES - 1;

  rtcsc_pkg::cfg_t   cfg_q;
  rtcsc_pkg::tval_t  mval_d, rval_d, mval_q, rval_q;
  rtcsc_pkg::adv_t   adv;
  logic              mok_d, rok_d, m_time_ok, r_time_ok;
  logic [LAST:0]     v_q, rdy;
  logic [LAST-1:0]   mok_q, rok_q;
  logic [31:0]       msecs, rsecs, diff;
  rtcsc_pkg::verdict_e verdict_d, verdict_q;
  logic              write_d, write_q;
  logic [31:0]       drift_d, drift_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_year    <= rtcsc_pkg::RST_MIN_YEAR;
      cfg_q.min_month   <= rtcsc_pkg::RST_MIN_MONTH;
      cfg_q.min_day     <= rtcsc_pkg::RST_MIN_DAY;
      cfg_q.drift_limit <= rtcsc_pkg::RST_DRIFT_LIMIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rtcsc_pkg::CFG_MIN_YEAR:    cfg_q.min_year    <= cfg_data_i[6:0];
        rtcsc_pkg::CFG_MIN_MONTH:   cfg_q.min_month   <= cfg_data_i[3:0];
        rtcsc_pkg::CFG_MIN_DAY:     cfg_q.min_day     <= cfg_data_i[4:0];
        rtcsc_pkg::CFG_DRIFT_LIMIT: cfg_q.drift_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its successor takes its item.
  always_comb begin
    rdy[LAST] = !v_q[LAST] || out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];
  assign adv.s2 = rdy[1];
  assign adv.s3 = rdy[2];
  assign adv.s4 = rdy[3];
  assign adv.s5 = rdy[4];

  // Stage one: decode and check both times.
  rtcsc_time_dec u_mdec (
    .time_i (master_time_i),
    .cfg_i  (cfg_q),
    .val_o  (mval_d),
    .ok_o   (m_time_ok)
  );

  rtcsc_time_dec u_rdec (
    .time_i (rtc_time_i),
    .cfg_i  (cfg_q),
    .val_o  (rval_d),
    .ok_o   (r_time_ok)
  );

  assign mok_d = (master_count_i == rtcsc_pkg::MASTER_BYTES) && m_time_ok;
  assign rok_d = rtc_read_ok_i && r_time_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      mval_q   <= mval_d;
      rval_q   <= rval_d;
      mok_q[0] <= mok_d;
      rok_q[0] <= rok_d;
    end
    for (int k = 1; k < LAST; k++) begin
      if (rdy[k]) begin
        mok_q[k] <= mok_q[k-1];
        rok_q[k] <= rok_q[k-1];
      end
    end
  end

  // Stages two to five: second counts of both times.
  rtcsc_sec_pipe u_msec (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (mval_q),
    .secs_o (msecs)
  );

  rtcsc_sec_pipe u_rsec (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .val_i  (rval_q),
    .secs_o (rsecs)
  );

  // Stage six: drift and verdict into the output register.
  assign diff = (msecs > rsecs) ? (msecs - rsecs) : (rsecs - msecs);

  always_comb begin
    verdict_d = rtcsc_pkg::VERDICT_REJECT;
    write_d   = 1'b0;
    drift_d   = '0;
    if (!mok_q[LAST-1]) begin
      verdict_d = rtcsc_pkg::VERDICT_REJECT;
    end else if (!rok_q[LAST-1]) begin
      verdict_d = rtcsc_pkg::VERDICT_RTC_BAD;
      write_d   = 1'b1;
    end else begin
      drift_d = diff;
      if (diff > 32'(cfg_q.drift_limit)) begin
        verdict_d = rtcsc_pkg::VERDICT_DRIFT;
        write_d   = 1'b1;
      end else begin
        verdict_d = rtcsc_pkg::VERDICT_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[LAST]) begin
      verdict_q <= verdict_d;
      write_q   <= write_d;
      drift_q   <= drift_d;
    end
  end

  assign out_valid_o     = v_q[LAST];
  assign verdict_o       = verdict_q;
  assign write_rtc_o     = write_q;
  assign drift_seconds_o = drift_q;

endmodule

// ===== hdl/rtcsc_checker.sv =====
// Port-level checker for the time synchronisation check, bound to the top level.
// Depends on rtcsc_pkg and rtc_time_sync_check_unit_defines.svh.
`include "rtc_time_sync_check_unit_defines.svh"

module rtcsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  verdict_o,
  input logic        write_rtc_o,
  input logic [31:0] drift_seconds_o
);

  // A result that is not transferred must stay offered unchanged.
  `RTCSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(verdict_o) && $stable(write_rtc_o) && $stable(drift_seconds_o), "output result changed while stalled")

  // A rejected master packet never writes the clock and reports no drift.
  `RTCSC_ASSERT_NOW(a_reject_quiet, out_valid_o && verdict_o == rtcsc_pkg::VERDICT_REJECT, !write_rtc_o && drift_seconds_o == 32'd0, "rejected packet with write or drift")

  // An unusable clock reading forces a write and reports no drift.
  `RTCSC_ASSERT_NOW(a_rtc_bad_write, out_valid_o && verdict_o == rtcsc_pkg::VERDICT_RTC_BAD, write_rtc_o && drift_seconds_o == 32'd0, "bad clock reading without write")

  // Drift within the limit must not rewrite the clock; excess drift must.
  `RTCSC_ASSERT_NOW(a_write_match, out_valid_o && (verdict_o == rtcsc_pkg::VERDICT_OK || verdict_o == rtcsc_pkg::VERDICT_DRIFT), write_rtc_o == (verdict_o == rtcsc_pkg::VERDICT_DRIFT), "write flag disagrees with drift verdict")

endmodule

bind rtc_time_sync_check_unit rtcsc_checker u_rtcsc_checker (.*);
